### sv/mtok_pkg.sv
// Package for the markup tokenizer: types, codes and character classes.
`default_nettype none
package mtok_pkg;

  localparam int LINE_BITS = 16;
  localparam int COL_BITS  = 12;

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [COL_BITS-1:0]  COL_MAX  = {COL_BITS{1'b1}};

  // lexer modes
  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_SLASH = 4'd1,
    M_LCOM  = 4'd2,
    M_BCOM  = 4'd3,
    M_BSTAR = 4'd4,
    M_STR   = 4'd5,
    M_ESC   = 4'd6,
    M_AFTER = 4'd7,
    M_NUM   = 4'd8,
    M_KW    = 4'd9,
    M_DIR   = 4'd10
  } mode_t;

  // token kinds
  localparam logic [3:0] KIND_EOF    = 4'd0;
  localparam logic [3:0] KIND_COLON  = 4'd1;
  localparam logic [3:0] KIND_COMMA  = 4'd2;
  localparam logic [3:0] KIND_EQUAL  = 4'd3;
  localparam logic [3:0] KIND_PLUS   = 4'd4;
  localparam logic [3:0] KIND_AT     = 4'd5;
  localparam logic [3:0] KIND_LPAREN = 4'd6;
  localparam logic [3:0] KIND_RPAREN = 4'd7;
  localparam logic [3:0] KIND_LCURLY = 4'd8;
  localparam logic [3:0] KIND_RCURLY = 4'd9;
  localparam logic [3:0] KIND_STRING = 4'd10;
  localparam logic [3:0] KIND_INT    = 4'd11;
  localparam logic [3:0] KIND_FLOAT  = 4'd12;
  localparam logic [3:0] KIND_BOOL   = 4'd13;
  localparam logic [3:0] KIND_KEYWD  = 4'd14;
  localparam logic [3:0] KIND_DIRECT = 4'd15;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_SYMBOL  = 2'd1;
  localparam logic [1:0] ERR_STR_EOF = 2'd2;

  // bool match progress: 1..4 along "true", 5..9 along "false"
  localparam logic [3:0] BM_NONE      = 4'd0;
  localparam logic [3:0] BM_T         = 4'd1;
  localparam logic [3:0] BM_TRUE_END  = 4'd4;
  localparam logic [3:0] BM_F         = 4'd5;
  localparam logic [3:0] BM_FALSE_END = 4'd9;

  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AT     = 8'h40;

  typedef struct packed {
    mode_t                mode;
    logic                 dot;
    logic [3:0]           bm;
    logic [LINE_BITS-1:0] line;
    logic [COL_BITS-1:0]  col;
    logic [COL_BITS-1:0]  tstart;
    logic                 halted;
    logic [LINE_BITS-1:0] tline;
    logic [COL_BITS-1:0]  tend;
    logic [COL_BITS-1:0]  scol;
    logic                 joining;
  } lex_st_t;

  typedef struct packed {
    logic                 is_end;
    logic [3:0]           kind;
    logic [7:0]           val;
    logic [LINE_BITS-1:0] line;
    logic [COL_BITS-1:0]  sc;
    logic [COL_BITS-1:0]  ec;
    logic [1:0]           err;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return is_digit(c) || c == CH_DOT || c == CH_DASH;
  endfunction

  function automatic logic is_kw(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_DOT;
  endfunction

  // single-character punctuation, KIND_EOF when none
  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      8'h3a:   k = KIND_COLON;
      8'h2c:   k = KIND_COMMA;
      8'h3d:   k = KIND_EQUAL;
      8'h2b:   k = KIND_PLUS;
      CH_AT:   k = KIND_AT;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7b:   k = KIND_LCURLY;
      8'h7d:   k = KIND_RCURLY;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] bool_next(input logic [3:0] bm, input logic [7:0] c);
    logic [7:0] want;
    logic       track;
    track = 1'b1;
    case (bm)
      4'd1:    want = 8'h72; // r
      4'd2:    want = 8'h75; // u
      4'd3:    want = 8'h65; // e
      4'd5:    want = 8'h61; // a
      4'd6:    want = 8'h6c; // l
      4'd7:    want = 8'h73; // s
      4'd8:    want = 8'h65; // e
      default: begin
        want  = 8'h00;
        track = 1'b0;
      end
    endcase
    return (track && c == want) ? bm + 4'd1 : BM_NONE;
  endfunction

endpackage
`default_nettype wire

### sv/markup_tokenizer.sv
// Top level of the markup tokenizer: lexer state, item register and result register.
`default_nettype none
// Streaming markup tokenizer. Each input beat is one source byte (in_tdata) or,
// with in_tuser set, the end marker of a document. Whitespace and comments are
// dropped; value characters of strings, numbers, keywords and directives come out
// one beat each, and every token closes with an end beat that carries kind, line
// and start/end columns. A bad symbol reports an error and mutes the block until
// the next end marker. Rate: one input beat per cycle for bytes that cause no
// result, and for bytes that cause one result while the output is not stalled;
// a byte or end marker that causes two results (a pending token closed plus a
// new token or eof/error) holds the input until both are sent, since the single
// output register takes one result beat per cycle. The output register lets the
// next byte be taken while a result waits for out_tready.
module markup_tokenizer
  import mtok_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_char
  input  wire logic        in_tuser,   // [0] end_of_input
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [55:0] out_tdata,  // [7:0] value_char, [23:8] line,
                                       // [35:24] start_col, [47:36] end_col,
                                       // [49:48] error_code, [55:50] zero
  output      logic [4:0]  out_tuser,  // [0] is_token_end, [4:1] token_kind
  output      logic        out_tlast   // last result of the input beat
);

  localparam lex_st_t ST_RESET = '{mode: M_IDLE, dot: 1'b0, bm: BM_NONE,
                                   line: '0, col: '0, tstart: '0, halted: 1'b0,
                                   tline: '0, tend: '0, scol: '0, joining: 1'b0};

  lex_st_t    st_r, st_nxt;
  logic       item_v_r, item_v_nxt;
  logic [7:0] item_c_r;
  logic       item_e_r;
  logic       idx_r, idx_nxt;
  logic       out_v_r, out_v_nxt;
  res_t       out_res_r, out_res_nxt;
  logic       out_last_r, out_last_nxt;

  // results of the held item against the current lexer state
  res_t       res [2];
  logic [1:0] cnt;
  lex_st_t    ns;
  logic       done;
  logic       out_free;

  function automatic res_t mk(input logic e, input logic [3:0] k, input logic [7:0] v,
                              input logic [LINE_BITS-1:0] ln,
                              input logic [COL_BITS-1:0] sc,
                              input logic [COL_BITS-1:0] ec, input logic [1:0] err);
    res_t r;
    r.is_end = e;
    r.kind   = k;
    r.val    = v;
    r.line   = ln;
    r.sc     = sc;
    r.ec     = ec;
    r.err    = err;
    return r;
  endfunction

  // token end for the pending token
  function automatic res_t finish(input lex_st_t s);
    logic [3:0] k;
    if (s.joining) begin
      k = KIND_STRING;
    end else if (s.mode == M_NUM) begin
      k = s.dot ? KIND_FLOAT : KIND_INT;
    end else if (s.mode == M_KW) begin
      k = (s.bm == BM_TRUE_END || s.bm == BM_FALSE_END) ? KIND_BOOL : KIND_KEYWD;
    end else begin
      k = KIND_DIRECT;
    end
    return mk(1'b1, k, 8'h00, s.tline, s.tstart, s.tend, ERR_NONE);
  endfunction

  // lexer step
  always_comb begin
    logic [7:0]          c;
    logic [COL_BITS-1:0] cur;
    logic                go_idle;
    logic [3:0]          pk;
    c       = item_c_r;
    cur     = st_r.col;
    ns      = st_r;
    cnt     = 2'd0;
    go_idle = 1'b0;
    res[0]  = '0;
    res[1]  = '0;
    pk      = punct_kind(c);

    if (st_r.halted) begin
      if (item_e_r) ns = ST_RESET;
    end else if (item_e_r) begin
      case (st_r.mode)
        M_STR, M_ESC: begin
          res[0] = mk(1'b1, KIND_STRING, 8'h00, st_r.tline, st_r.tstart, st_r.col,
                      ERR_STR_EOF);
          cnt = 2'd1;
        end
        M_SLASH: begin
          if (st_r.joining) begin
            res[cnt[0]] = finish(st_r);
            cnt = cnt + 2'd1;
          end
          res[cnt[0]] = mk(1'b1, KIND_EOF, CH_SLASH, st_r.line, st_r.scol, st_r.scol,
                           ERR_SYMBOL);
          cnt = cnt + 2'd1;
        end
        M_LCOM, M_BCOM, M_BSTAR, M_AFTER, M_NUM, M_KW, M_DIR: begin
          if (st_r.joining || st_r.mode == M_AFTER || st_r.mode == M_NUM ||
              st_r.mode == M_KW || st_r.mode == M_DIR) begin
            res[cnt[0]] = finish(st_r);
            cnt = cnt + 2'd1;
          end
          res[cnt[0]] = mk(1'b1, KIND_EOF, 8'h00, st_r.line, st_r.col, st_r.col, ERR_NONE);
          cnt = cnt + 2'd1;
        end
        default: begin
          res[0] = mk(1'b1, KIND_EOF, 8'h00, st_r.line, st_r.col, st_r.col, ERR_NONE);
          cnt = 2'd1;
        end
      endcase
      ns = ST_RESET;
    end else begin
      case (st_r.mode)
        M_SLASH: begin
          if (c == CH_SLASH) begin
            ns.mode = M_LCOM;
          end else if (c == CH_STAR) begin
            ns.mode = M_BCOM;
          end else begin
            if (st_r.joining) begin
              res[cnt[0]] = finish(st_r);
              cnt = cnt + 2'd1;
              ns.joining = 1'b0;
            end
            res[cnt[0]] = mk(1'b1, KIND_EOF, CH_SLASH, st_r.line, st_r.scol, st_r.scol,
                             ERR_SYMBOL);
            cnt = cnt + 2'd1;
            ns.halted = 1'b1;
            ns.mode   = M_IDLE;
          end
        end
        M_LCOM: begin
          if (c == CH_LF) ns.mode = st_r.joining ? M_AFTER : M_IDLE;
        end
        M_BCOM: begin
          if (c == CH_STAR) ns.mode = M_BSTAR;
        end
        M_BSTAR: begin
          if (c == CH_SLASH) ns.mode = st_r.joining ? M_AFTER : M_IDLE;
          else if (c != CH_STAR) ns.mode = M_BCOM;
        end
        M_STR: begin
          if (c == CH_BSLASH) begin
            ns.mode = M_ESC;
          end else if (c == CH_QUOTE) begin
            ns.tend    = cur;
            ns.mode    = M_AFTER;
            ns.joining = 1'b1;
          end else begin
            res[0] = mk(1'b0, KIND_STRING, c, st_r.line, st_r.tstart, cur, ERR_NONE);
            cnt = 2'd1;
          end
        end
        M_ESC: begin
          res[0] = mk(1'b0, KIND_STRING, c, st_r.line, st_r.tstart, cur, ERR_NONE);
          cnt = 2'd1;
          ns.mode = M_STR;
        end
        M_AFTER: begin
          if (is_space(c)) begin
            ns.mode = M_AFTER;
          end else if (c == CH_QUOTE) begin
            ns.mode = M_STR;
          end else if (c == CH_SLASH) begin
            ns.mode = M_SLASH;
            ns.scol = cur;
          end else begin
            res[0] = finish(st_r);
            cnt = 2'd1;
            go_idle = 1'b1;
          end
        end
        M_NUM: begin
          if (is_num(c)) begin
            if (c == CH_DOT) ns.dot = 1'b1;
            ns.tend = cur;
            res[0] = mk(1'b0, KIND_INT, c, st_r.line, st_r.tstart, cur, ERR_NONE);
            cnt = 2'd1;
          end else begin
            res[0] = finish(st_r);
            cnt = 2'd1;
            go_idle = 1'b1;
          end
        end
        M_KW: begin
          if (is_kw(c)) begin
            ns.bm   = bool_next(st_r.bm, c);
            ns.tend = cur;
            res[0] = mk(1'b0, KIND_KEYWD, c, st_r.line, st_r.tstart, cur, ERR_NONE);
            cnt = 2'd1;
          end else begin
            res[0] = finish(st_r);
            cnt = 2'd1;
            go_idle = 1'b1;
          end
        end
        M_DIR: begin
          if (is_kw(c)) begin
            ns.tend = cur;
            res[0] = mk(1'b0, KIND_DIRECT, c, st_r.line, st_r.tstart, cur, ERR_NONE);
            cnt = 2'd1;
          end else begin
            res[0] = finish(st_r);
            cnt = 2'd1;
            go_idle = 1'b1;
          end
        end
        default: go_idle = 1'b1;
      endcase

      // start of a new token from idle
      if (go_idle) begin
        ns.mode    = M_IDLE;
        ns.joining = 1'b0;
        if (c == CH_SLASH) begin
          ns.mode = M_SLASH;
          ns.scol = cur;
        end else if (is_space(c)) begin
          ns.mode = M_IDLE;
        end else if (pk != KIND_EOF) begin
          res[cnt[0]] = mk(1'b1, pk, 8'h00, st_r.line, cur, cur, ERR_NONE);
          cnt = cnt + 2'd1;
        end else if (c == CH_HASH || c == CH_QUOTE) begin
          ns.mode   = (c == CH_HASH) ? M_DIR : M_STR;
          ns.tline  = st_r.line;
          ns.tstart = cur;
          ns.tend   = cur;
        end else if (is_num(c)) begin
          ns.mode   = M_NUM;
          ns.dot    = (c == CH_DOT);
          ns.tline  = st_r.line;
          ns.tstart = cur;
          ns.tend   = cur;
          res[cnt[0]] = mk(1'b0, KIND_INT, c, st_r.line, cur, cur, ERR_NONE);
          cnt = cnt + 2'd1;
        end else if (is_alpha(c) || c == CH_UNDER) begin
          ns.mode   = M_KW;
          ns.bm     = (c == 8'h74) ? BM_T : ((c == 8'h66) ? BM_F : BM_NONE);
          ns.tline  = st_r.line;
          ns.tstart = cur;
          ns.tend   = cur;
          res[cnt[0]] = mk(1'b0, KIND_KEYWD, c, st_r.line, cur, cur, ERR_NONE);
          cnt = cnt + 2'd1;
        end else begin
          res[cnt[0]] = mk(1'b1, KIND_EOF, c, st_r.line, cur, cur, ERR_SYMBOL);
          cnt = cnt + 2'd1;
          ns.halted = 1'b1;
          ns.mode   = M_IDLE;
        end
      end

      // position update, saturating
      if (c == CH_LF) begin
        if (st_r.line != LINE_MAX) ns.line = st_r.line + 1'b1;
        ns.col = '0;
      end else if (st_r.col != COL_MAX) begin
        ns.col = st_r.col + 1'b1;
      end
    end
  end

  // drain held item: a beat per cycle if output free; state commits on last beat
  always_comb begin
    out_free     = !out_v_r || out_tready;
    done         = 1'b0;
    idx_nxt      = idx_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_res_nxt  = out_res_r;
    out_last_nxt = out_last_r;
    st_nxt       = st_r;
    if (item_v_r) begin
      if (cnt == 2'd0) begin
        done = 1'b1;
      end else if (out_free) begin
        out_v_nxt    = 1'b1;
        out_res_nxt  = res[idx_r];
        out_last_nxt = ({1'b0, idx_r} == cnt - 2'd1);
        if (out_last_nxt) begin
          done    = 1'b1;
          idx_nxt = 1'b0;
        end else begin
          idx_nxt = 1'b1;
        end
      end
    end
    if (done) st_nxt = ns;
    in_tready  = !item_v_r || done;
    item_v_nxt = (item_v_r && !done) || in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_RESET;
      item_v_r <= 1'b0;
      idx_r    <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      item_v_r <= in_tready ? in_tvalid : item_v_nxt;
      idx_r    <= idx_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_c_r <= in_tdata;
      item_e_r <= in_tuser;
    end
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_res_r.kind, out_res_r.is_end};
  assign out_tdata  = {6'b0, out_res_r.err, out_res_r.ec, out_res_r.sc,
                       out_res_r.line, out_res_r.val};

endmodule
`default_nettype wire

### tb/sv/tb_markup_tokenizer.sv
// Self-checking testbench for markup_tokenizer: directed table, random documents, predictor.
module tb_markup_tokenizer
  import mtok_pkg::*;
();

  localparam int DIR_ROWS    = 28;
  localparam int RAND_ITEMS  = 370;   // source beats in the random part
  localparam int STALL_LIMIT = 5000;  // cycles with no beat on either side
  localparam int SHOW_MAX    = 10;
  localparam int DRAIN_WAIT  = 8;     // extra wait after the last expected beat

  // one result beat as the block presents it, plus tlast
  typedef struct packed {
    logic                 is_end;
    logic [3:0]           kind;
    logic [7:0]           val;
    logic [LINE_BITS-1:0] line;
    logic [COL_BITS-1:0]  sc;
    logic [COL_BITS-1:0]  ec;
    logic [1:0]           err;
    logic                 last;
  } tok_beat_t;

  // one source beat; typed rows carry their expected single result beat
  typedef struct packed {
    logic       eoi;
    logic [7:0] ch;
    logic       typed;
    tok_beat_t  want;
  } src_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] in_char
  logic        in_tuser;   // [0] end_of_input
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // [7:0] value_char, [23:8] line, [35:24] start_col,
                           // [47:36] end_col, [49:48] error_code
  logic [4:0]  out_tuser;  // [0] is_token_end, [4:1] token_kind
  logic        out_tlast;

  markup_tokenizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Lexer predictor: own copy of the tokenizer state
  // ---------------------------------------------------------------------------
  mode_t                lx_mode;
  logic                 lx_dot;
  logic [3:0]           lx_bm;
  logic [LINE_BITS-1:0] lx_line;
  logic [COL_BITS-1:0]  lx_col;
  logic [COL_BITS-1:0]  lx_tstart;
  logic                 lx_halted;
  logic [LINE_BITS-1:0] lx_tline;
  logic [COL_BITS-1:0]  lx_tend;
  logic [COL_BITS-1:0]  lx_scol;
  logic                 lx_join;

  tok_beat_t exp_beats_q[$];  // token beats still owed by the block
  src_beat_t stim_q[$];
  src_beat_t dir_tab [DIR_ROWS];

  int bad_beats;
  int idle_cycles;
  int text_items;

  function automatic logic ws_byte(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic numrun_byte(input logic [7:0] c);
    return digit_byte(c) || c == CH_DOT || c == CH_DASH;
  endfunction

  function automatic logic word_byte(input logic [7:0] c);
    return letter_byte(c) || digit_byte(c) || c == CH_UNDER || c == CH_DOT;
  endfunction

  function automatic logic [3:0] punct_code(input logic [7:0] c);
    logic [3:0] k;
    k = KIND_EOF;
    if (c == ":") k = KIND_COLON;
    else if (c == ",") k = KIND_COMMA;
    else if (c == "=") k = KIND_EQUAL;
    else if (c == "+") k = KIND_PLUS;
    else if (c == CH_AT) k = KIND_AT;
    else if (c == "(") k = KIND_LPAREN;
    else if (c == ")") k = KIND_RPAREN;
    else if (c == "{") k = KIND_LCURLY;
    else if (c == "}") k = KIND_RCURLY;
    return k;
  endfunction

  // progress along "true" (1..4) or "false" (5..9)
  function automatic logic [3:0] bool_step(input logic [3:0] bm, input logic [7:0] c);
    logic [3:0] nx;
    nx = BM_NONE;
    case (bm)
      4'd1: if (c == "r") nx = 4'd2;
      4'd2: if (c == "u") nx = 4'd3;
      4'd3: if (c == "e") nx = BM_TRUE_END;
      4'd5: if (c == "a") nx = 4'd6;
      4'd6: if (c == "l") nx = 4'd7;
      4'd7: if (c == "s") nx = 4'd8;
      4'd8: if (c == "e") nx = BM_FALSE_END;
      default: nx = BM_NONE;
    endcase
    return nx;
  endfunction

  function automatic tok_beat_t mk_beat(input logic is_end, input logic [3:0] kind,
                                        input logic [7:0] val, input logic [LINE_BITS-1:0] line,
                                        input logic [COL_BITS-1:0] sc,
                                        input logic [COL_BITS-1:0] ec, input logic [1:0] err);
    tok_beat_t b;
    b.is_end = is_end;
    b.kind   = kind;
    b.val    = val;
    b.line   = line;
    b.sc     = sc;
    b.ec     = ec;
    b.err    = err;
    b.last   = 1'b0;
    return b;
  endfunction

  task automatic clear_doc();
    lx_mode   = M_IDLE;
    lx_dot    = 1'b0;
    lx_bm     = BM_NONE;
    lx_line   = '0;
    lx_col    = '0;
    lx_tstart = '0;
    lx_halted = 1'b0;
    lx_tline  = '0;
    lx_tend   = '0;
    lx_scol   = '0;
    lx_join   = 1'b0;
  endtask

  task automatic note(input logic is_end, input logic [3:0] kind, input logic [7:0] val,
                      input logic [LINE_BITS-1:0] line, input logic [COL_BITS-1:0] sc,
                      input logic [COL_BITS-1:0] ec, input logic [1:0] err);
    exp_beats_q.insert(exp_beats_q.size(), mk_beat(is_end, kind, val, line, sc, ec, err));
  endtask

  task automatic open_token(input logic [COL_BITS-1:0] cur);
    lx_tline  = lx_line;
    lx_tstart = cur;
    lx_tend   = cur;
  endtask

  // token end beat for whatever is pending; joined strings win over the mode
  task automatic close_token();
    logic [3:0] k;
    if (lx_join) k = KIND_STRING;
    else if (lx_mode == M_NUM) k = lx_dot ? KIND_FLOAT : KIND_INT;
    else if (lx_mode == M_KW)
      k = (lx_bm == BM_TRUE_END || lx_bm == BM_FALSE_END) ? KIND_BOOL : KIND_KEYWD;
    else k = KIND_DIRECT;
    note(1'b1, k, 8'h00, lx_tline, lx_tstart, lx_tend, ERR_NONE);
    lx_mode = M_IDLE;
    lx_join = 1'b0;
  endtask

  task automatic bad_symbol(input logic [7:0] c, input logic [COL_BITS-1:0] colv);
    note(1'b1, KIND_EOF, c, lx_line, colv, colv, ERR_SYMBOL);
    lx_halted = 1'b1;
    lx_mode   = M_IDLE;
  endtask

  task automatic fresh_char(input logic [7:0] c, input logic [COL_BITS-1:0] cur);
    logic [3:0] k;
    k       = punct_code(c);
    lx_mode = M_IDLE;
    lx_join = 1'b0;
    if (c == CH_SLASH) begin
      lx_mode = M_SLASH;
      lx_scol = cur;
    end else if (ws_byte(c)) begin
    end else if (k != KIND_EOF) begin
      note(1'b1, k, 8'h00, lx_line, cur, cur, ERR_NONE);
    end else if (c == CH_HASH) begin
      lx_mode = M_DIR;
      open_token(cur);
    end else if (c == CH_QUOTE) begin
      lx_mode = M_STR;
      open_token(cur);
    end else if (numrun_byte(c)) begin
      lx_mode = M_NUM;
      lx_dot  = (c == CH_DOT);
      open_token(cur);
      note(1'b0, KIND_INT, c, lx_line, cur, cur, ERR_NONE);
    end else if (letter_byte(c) || c == CH_UNDER) begin
      lx_mode = M_KW;
      lx_bm   = (c == "t") ? BM_T : ((c == "f") ? BM_F : BM_NONE);
      open_token(cur);
      note(1'b0, KIND_KEYWD, c, lx_line, cur, cur, ERR_NONE);
    end else begin
      bad_symbol(c, cur);
    end
  endtask

  // advance the predictor by one accepted source beat
  task automatic tokenize_step(input logic [7:0] c, input logic eoi);
    logic [COL_BITS-1:0] cur;
    int                  n0;
    tok_beat_t           tail;
    cur = lx_col;
    n0  = exp_beats_q.size();
    if (lx_halted) begin
      // muted until the end marker, which then opens a fresh document silently
      if (eoi) clear_doc();
    end else if (eoi) begin
      case (lx_mode)
        M_STR, M_ESC:
          note(1'b1, KIND_STRING, 8'h00, lx_tline, lx_tstart, lx_col, ERR_STR_EOF);
        M_SLASH: begin
          if (lx_join) close_token();
          note(1'b1, KIND_EOF, CH_SLASH, lx_line, lx_scol, lx_scol, ERR_SYMBOL);
        end
        M_IDLE:
          note(1'b1, KIND_EOF, 8'h00, lx_line, lx_col, lx_col, ERR_NONE);
        default: begin
          // open comments just end; any pending token is closed before eof
          if (lx_join || !(lx_mode == M_LCOM || lx_mode == M_BCOM || lx_mode == M_BSTAR))
            close_token();
          note(1'b1, KIND_EOF, 8'h00, lx_line, lx_col, lx_col, ERR_NONE);
        end
      endcase
      clear_doc();
    end else begin
      case (lx_mode)
        M_SLASH: begin
          if (c == CH_SLASH) lx_mode = M_LCOM;
          else if (c == CH_STAR) lx_mode = M_BCOM;
          else begin
            if (lx_join) close_token();
            bad_symbol(CH_SLASH, lx_scol);
          end
        end
        M_LCOM: if (c == CH_LF) lx_mode = lx_join ? M_AFTER : M_IDLE;
        M_BCOM: if (c == CH_STAR) lx_mode = M_BSTAR;
        M_BSTAR: begin
          if (c == CH_SLASH) lx_mode = lx_join ? M_AFTER : M_IDLE;
          else if (c != CH_STAR) lx_mode = M_BCOM;
        end
        M_STR: begin
          if (c == CH_BSLASH) lx_mode = M_ESC;
          else if (c == CH_QUOTE) begin
            lx_tend = cur;
            lx_mode = M_AFTER;
            lx_join = 1'b1;
          end else note(1'b0, KIND_STRING, c, lx_line, lx_tstart, cur, ERR_NONE);
        end
        M_ESC: begin
          note(1'b0, KIND_STRING, c, lx_line, lx_tstart, cur, ERR_NONE);
          lx_mode = M_STR;
        end
        M_AFTER: begin
          // between joined strings: whitespace and comments keep the token open
          if (ws_byte(c)) begin
          end else if (c == CH_QUOTE) lx_mode = M_STR;
          else if (c == CH_SLASH) begin
            lx_mode = M_SLASH;
            lx_scol = cur;
          end else begin
            close_token();
            fresh_char(c, cur);
          end
        end
        M_NUM: begin
          if (numrun_byte(c)) begin
            if (c == CH_DOT) lx_dot = 1'b1;
            lx_tend = cur;
            note(1'b0, KIND_INT, c, lx_line, lx_tstart, cur, ERR_NONE);
          end else begin
            close_token();
            fresh_char(c, cur);
          end
        end
        M_KW: begin
          if (word_byte(c)) begin
            lx_bm   = bool_step(lx_bm, c);
            lx_tend = cur;
            note(1'b0, KIND_KEYWD, c, lx_line, lx_tstart, cur, ERR_NONE);
          end else begin
            close_token();
            fresh_char(c, cur);
          end
        end
        M_DIR: begin
          if (word_byte(c)) begin
            lx_tend = cur;
            note(1'b0, KIND_DIRECT, c, lx_line, lx_tstart, cur, ERR_NONE);
          end else begin
            close_token();
            fresh_char(c, cur);
          end
        end
        default: fresh_char(c, cur);
      endcase
      // position counters saturate
      if (c == CH_LF) begin
        if (lx_line != LINE_MAX) lx_line = lx_line + 1'b1;
        lx_col = '0;
      end else if (lx_col != COL_MAX) begin
        lx_col = lx_col + 1'b1;
      end
    end
    if (exp_beats_q.size() > n0) begin
      tail      = exp_beats_q[exp_beats_q.size() - 1];
      tail.last = 1'b1;
      exp_beats_q[exp_beats_q.size() - 1] = tail;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic src_beat_t src(input logic eoi, input logic [7:0] c);
    src_beat_t s;
    s     = '0;
    s.eoi = eoi;
    s.ch  = c;
    return s;
  endfunction

  function automatic src_beat_t srcx(input logic eoi, input logic [7:0] c, input tok_beat_t w);
    src_beat_t s;
    s       = src(eoi, c);
    s.typed = 1'b1;
    s.want  = w;
    return s;
  endfunction

  // token end beat closing the item, for typed rows
  function automatic tok_beat_t fin(input logic [3:0] kind, input logic [7:0] val,
                                    input logic [COL_BITS-1:0] sc,
                                    input logic [COL_BITS-1:0] ec, input logic [1:0] err);
    tok_beat_t b;
    b      = mk_beat(1'b1, kind, val, '0, sc, ec, err);
    b.last = 1'b1;
    return b;
  endfunction

  task automatic put(input logic [7:0] c);
    stim_q.insert(stim_q.size(), src(1'b0, c));
    text_items++;
  endtask

  task automatic put_end();
    stim_q.insert(stim_q.size(), src(1'b1, 8'($urandom_range(0, 255))));
    text_items++;
  endtask

  task automatic put_text(input string t);
    foreach (t[i]) put(t[i]);
  endtask

  function automatic logic [7:0] pick(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic logic [7:0] ws_pick();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = 8'h09;
      1:       c = CH_LF;
      2:       c = 8'h0b;
      3:       c = 8'h0c;
      4:       c = 8'h0d;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  task automatic put_string();
    logic [7:0] c;
    put(CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 4) == 0) begin
        // escape: any byte at all, quote and backslash included
        put(CH_BSLASH);
        put(8'($urandom_range(0, 255)));
      end else begin
        c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE || c == CH_BSLASH) c = 8'($urandom_range(0, 255));
        put(c);
      end
    end
    put(CH_QUOTE);
  endtask

  task automatic put_fragment();
    int r;
    r = $urandom_range(0, 99);
    if (r < 14) begin
      put(pick(":,=+@(){}"));
    end else if (r < 26) begin
      repeat ($urandom_range(1, 6)) put(pick("0123456789012345.-"));
    end else if (r < 42) begin
      case ($urandom_range(0, 4))
        0: put_text("true");
        1: put_text("false");
        2: begin
          case ($urandom_range(0, 3))
            0: put_text("tru");
            1: put_text("fals");
            2: put_text("truex");
            default: put_text("false_");
          endcase
        end
        default: begin
          put(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_tf"));
          repeat ($urandom_range(0, 5)) put(pick("aeiouxyztf_.0129RS"));
        end
      endcase
    end else if (r < 49) begin
      put(CH_HASH);
      repeat ($urandom_range(0, 4)) put(pick("abcxyz_.09Q"));
    end else if (r < 64) begin
      put_string();
      // strings separated only by whitespace or comments are joined
      while ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 2))
          0: put(ws_pick());
          1: begin put_text("/*x"); put(CH_LF); put_text("*/"); end
          default: begin put_text("// q"); put(CH_LF); end
        endcase
        put_string();
      end
    end else if (r < 79) begin
      repeat ($urandom_range(1, 3)) put(ws_pick());
    end else if (r < 87) begin
      put_text("//");
      repeat ($urandom_range(0, 6)) put(pick("ab */#1"));
      put(CH_LF);
    end else if (r < 94) begin
      put_text("/*");
      repeat ($urandom_range(0, 6)) put(pick("ab *#1"));
      put_text("*/");
    end else if (r < 97) begin
      put(8'($urandom_range(0, 255)));   // noise, usually an invalid symbol
    end else begin
      put(CH_SLASH);                     // lone slash
      put(pick("ab1 :"));
    end
  endtask

  task automatic put_document();
    repeat ($urandom_range(4, 20)) begin
      put_fragment();
      if ($urandom_range(0, 1) == 0) put(8'h20);
    end
    // unfinished constructs at the end marker
    case ($urandom_range(0, 19))
      0, 1: begin put(CH_QUOTE); put(pick("ab\\")); end
      2: put(CH_SLASH);
      3: put_text("/*ab");
      4: put_text("//ab");
      5: begin put_string(); put(8'h20); end
      default: begin end
    endcase
    put_end();
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: every accepted result beat against the oldest expectation
  // ---------------------------------------------------------------------------
  tok_beat_t got_beat;
  tok_beat_t want_beat;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_beat.is_end = out_tuser[0];
      got_beat.kind   = out_tuser[4:1];
      got_beat.val    = out_tdata[7:0];
      got_beat.line   = out_tdata[23:8];
      got_beat.sc     = out_tdata[35:24];
      got_beat.ec     = out_tdata[47:36];
      got_beat.err    = out_tdata[49:48];
      got_beat.last   = out_tlast;
      if (exp_beats_q.size() == 0) begin
        bad_beats++;
        if (bad_beats <= SHOW_MAX)
          $display("%0t: unexpected result beat end=%b kind=%0d val=%h line=%0d sc=%0d ec=%0d",
                   $time, got_beat.is_end, got_beat.kind, got_beat.val, got_beat.line,
                   got_beat.sc, got_beat.ec);
      end else begin
        want_beat = exp_beats_q.pop_front();
        if (got_beat !== want_beat) begin
          bad_beats++;
          if (bad_beats <= SHOW_MAX)
            $display({"%0t: result mismatch exp end=%b kind=%0d val=%h line=%0d sc=%0d ec=%0d",
                      " err=%0d last=%b | got end=%b kind=%0d val=%h line=%0d sc=%0d ec=%0d",
                      " err=%0d last=%b"},
                     $time, want_beat.is_end, want_beat.kind, want_beat.val, want_beat.line,
                     want_beat.sc, want_beat.ec, want_beat.err, want_beat.last,
                     got_beat.is_end, got_beat.kind, got_beat.val, got_beat.line,
                     got_beat.sc, got_beat.ec, got_beat.err, got_beat.last);
        end
      end
    end
  end

  // watchdog: too long without a beat on either side means the block hung
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_markup_tokenizer failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: switches between always ready, coin flip, sparse
  // ready, with an occasional long hold
  // ---------------------------------------------------------------------------
  int rx_mode;
  int rx_mode_left;
  int rx_hold_left;

  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_tready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
      if ($urandom_range(0, 99) == 0) rx_hold_left = $urandom_range(5, 30);
    end
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(20, 300);
    end else begin
      rx_mode_left = rx_mode_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, build stimulus, send in bursts, drain, verdict
  // ---------------------------------------------------------------------------
  int idx;
  int n0;
  int burst_left;
  int gap_left;

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    out_tready   = 1'b0;
    bad_beats    = 0;
    idle_cycles  = 0;
    text_items   = 0;
    rx_mode      = 0;
    rx_mode_left = 0;
    rx_hold_left = 0;
    clear_doc();

    // directed rows; typed ones close with a single beat that is known by eye
    dir_tab = '{
      srcx(1'b1, 8'h00, fin(KIND_EOF, 8'h00, '0, '0, ERR_NONE)),    // empty document
      srcx(1'b0, 8'h00, fin(KIND_EOF, 8'h00, '0, '0, ERR_SYMBOL)),  // zero byte
      src (1'b0, "x"),                                              // muted
      src (1'b1, 8'h00),                                            // silent restart
      srcx(1'b0, 8'hff, fin(KIND_EOF, 8'hff, '0, '0, ERR_SYMBOL)),  // top byte
      src (1'b1, 8'hff),
      srcx(1'b0, ":",   fin(KIND_COLON, 8'h00, '0, '0, ERR_NONE)),
      srcx(1'b0, "}",   fin(KIND_RCURLY, 8'h00, 12'd1, 12'd1, ERR_NONE)),
      src (1'b0, CH_QUOTE),
      src (1'b0, CH_BSLASH),                                        // doubled backslash
      src (1'b0, CH_BSLASH),
      src (1'b0, CH_BSLASH),                                        // escaped quote
      src (1'b0, CH_QUOTE),
      src (1'b0, CH_QUOTE),
      src (1'b0, 8'h20),                                            // join across space
      src (1'b0, CH_QUOTE),
      src (1'b0, CH_LF),                                            // newline in string
      src (1'b0, CH_QUOTE),
      src (1'b0, CH_SLASH),                                         // lone slash after join
      src (1'b0, "x"),
      src (1'b1, 8'h00),
      src (1'b0, CH_DASH),
      src (1'b0, CH_DOT),                                           // dot makes it float
      src (1'b0, "5"),
      src (1'b0, CH_HASH),                                          // empty directive
      src (1'b1, 8'h00),
      src (1'b0, CH_QUOTE),
      srcx(1'b1, 8'h00, fin(KIND_STRING, 8'h00, '0, 12'd1, ERR_STR_EOF)) // end inside string
    };
    for (int i = 0; i < DIR_ROWS; i++) stim_q.insert(stim_q.size(), dir_tab[i]);

    text_items = 0;
    while (text_items < RAND_ITEMS) put_document();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    burst_left = $urandom_range(1, 32);
    gap_left   = 0;
    for (idx = 0; idx < stim_q.size(); idx++) begin
      while (gap_left > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        gap_left = gap_left - 1;
      end
      @(negedge clk);
      in_tvalid <= 1'b1;
      in_tdata  <= stim_q[idx].ch;
      in_tuser  <= stim_q[idx].eoi;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      // beat accepted at this edge
      n0 = exp_beats_q.size();
      tokenize_step(stim_q[idx].ch, stim_q[idx].eoi);
      if (stim_q[idx].typed) begin
        while (exp_beats_q.size() > n0) exp_beats_q.delete(exp_beats_q.size() - 1);
        exp_beats_q.insert(exp_beats_q.size(), stim_q[idx].want);
      end
      burst_left = burst_left - 1;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        case ($urandom_range(0, 9))
          0, 1, 2: gap_left = 0;
          3:       gap_left = $urandom_range(10, 40);
          default: gap_left = $urandom_range(1, 6);
        endcase
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (exp_beats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (bad_beats == 0) begin
      $display("tb_markup_tokenizer passed");
    end else begin
      $display("tb_markup_tokenizer failed");
    end
    $finish;
  end

endmodule
